### src/aesm_pkg.sv
package aesm_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_FINISH
    } t_state;

    // cipher mode codes
    localparam logic [3:0] MODE_ECB_ENC  = 4'd0;
    localparam logic [3:0] MODE_ECB_DEC  = 4'd1;
    localparam logic [3:0] MODE_CBC_ENC  = 4'd2;
    localparam logic [3:0] MODE_CBC_DEC  = 4'd3;
    localparam logic [3:0] MODE_PCBC_ENC = 4'd4;
    localparam logic [3:0] MODE_PCBC_DEC = 4'd5;
    localparam logic [3:0] MODE_CFB_ENC  = 4'd6;
    localparam logic [3:0] MODE_CFB_DEC  = 4'd7;
    localparam logic [3:0] MODE_OFB_ENC  = 4'd8;
    localparam logic [3:0] MODE_OFB_DEC  = 4'd9;

    // key length codes
    localparam logic [1:0] KEYLEN_128 = 2'd0;
    localparam logic [1:0] KEYLEN_192 = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_WORD_0  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_1  = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_2  = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_3  = 3'd3;
    localparam logic [2:0] CFG_KEY_LENGTH  = 3'd4;
    localparam logic [2:0] CFG_CIPHER_MODE = 3'd5;
    localparam logic [2:0] CFG_IV_HIGH     = 3'd6;
    localparam logic [2:0] CFG_IV_LOW      = 3'd7;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       exp_step;
        logic [5:0] word_idx;
        logic       rd_en;
        logic [3:0] rd_row;
        logic       round;
        logic       round_first;
        logic       round_last;
        logic       finish;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [3:0] nr;
        logic       decrypt;
        logic       err;
    } t_status;

    typedef logic [7:0] t_sbox [256];

    function automatic logic [7:0] f_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] f_gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = f_xtime(x);
        end
        return p;
    endfunction

    function automatic logic [7:0] f_gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r = 8'h01;
        base = a;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = f_gf_mul(r, base);
            base = f_gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] f_rotl(input logic [7:0] x, input int n);
        logic [15:0] d;
        d = {x, x} << n;
        return d[15:8];
    endfunction

    // substitution tables, built at elaboration
    function automatic t_sbox f_build_sbox(input logic inverse);
        t_sbox tbl;
        logic [7:0] v;
        logic [7:0] x;
        for (int i = 0; i < 256; i++) begin
            v = 8'(i);
            if (inverse) begin
                x = f_rotl(v, 1) ^ f_rotl(v, 3) ^ f_rotl(v, 6) ^ 8'h05;
                tbl[i] = f_gf_inv(x);
            end else begin
                x = f_gf_inv(v);
                tbl[i] = x ^ f_rotl(x, 1) ^ f_rotl(x, 2) ^ f_rotl(x, 3) ^ f_rotl(x, 4)
                         ^ 8'h63;
            end
        end
        return tbl;
    endfunction

    localparam t_sbox SBOX     = f_build_sbox(1'b0);
    localparam t_sbox INV_SBOX = f_build_sbox(1'b1);

    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte n of the state sits at bits 127-8n downto 120-8n
    function automatic logic [127:0] f_sub_bytes(input logic [127:0] s, input logic inverse);
        logic [127:0] o;
        logic [7:0] b;
        for (int n = 0; n < 16; n++) begin
            b = s[127-8*n -: 8];
            o[127-8*n -: 8] = inverse ? INV_SBOX[b] : SBOX[b];
        end
        return o;
    endfunction

    function automatic logic [127:0] f_shift_rows(input logic [127:0] s, input logic inverse);
        logic [127:0] t;
        int o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o = r + 4 * ((c + r) & 3);
                if (inverse) t[127-8*o -: 8] = s[127-8*(r+4*c) -: 8];
                else t[127-8*(r+4*c) -: 8] = s[127-8*o -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] f_mix_columns(input logic [127:0] s, input logic inverse);
        logic [127:0] o;
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] v;
        if (inverse) begin
            m[0] = 8'h0E; m[1] = 8'h0B; m[2] = 8'h0D; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
            for (int r = 0; r < 4; r++) begin
                v = '0;
                for (int k = 0; k < 4; k++) v = v ^ f_gf_mul(m[(k - r) & 3], a[k]);
                o[127-8*(4*c+r) -: 8] = v;
            end
        end
        return o;
    endfunction

endpackage

### src/aesm_dp.sv
module aesm_dp #(
    parameter int unsigned MAX_ROUND_KEY_WORDS = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [255:0]      i_key,
    input  logic [1:0]        i_key_length,
    input  logic [3:0]        i_cipher_mode,
    input  logic [127:0]      i_iv,
    input  logic [63:0]       i_block_high,
    input  logic [63:0]       i_block_low,
    input  logic              i_first_block,
    input  logic [4:0]        i_byte_count,
    input  aesm_pkg::t_cmd    i_cmd,
    output aesm_pkg::t_status o_status,
    output logic [63:0]       o_result_high,
    output logic [63:0]       o_result_low,
    output logic              o_length_error
);
    import aesm_pkg::*;

    localparam int unsigned ROWS  = (MAX_ROUND_KEY_WORDS + 3) / 4;
    localparam int unsigned ROW_W = $clog2(ROWS);
    localparam logic [6:0]  MAX_WORDS = 7'(MAX_ROUND_KEY_WORDS);

    logic [127:0] r_state;
    logic [127:0] r_data;
    logic [127:0] r_mask;
    logic [127:0] r_chain;
    logic [3:0]   r_mode;
    logic         r_err;
    logic [31:0]  r_win [8];
    logic [2:0]   r_kmod;
    logic [7:0]   r_rcon;
    logic [31:0]  r_rk_rd [4];
    logic [3:0]   r_rd_row;
    logic [63:0]  r_res_high;
    logic [63:0]  r_res_low;
    logic         r_len_err;

    logic [3:0]   nk;
    logic [2:0]   nk_m1;
    logic [3:0]   nr;
    logic [4:0]   count_eff;
    logic [127:0] blk;
    logic [127:0] mask;
    logic [127:0] padded;
    logic [3:0]   mode_eff;
    logic [127:0] chain_eff;
    logic [127:0] cipher_in;
    logic         err_now;
    logic         decrypt;

    // key schedule length
    always_comb begin
        case (i_key_length)
            KEYLEN_128: nk = 4'd4;
            KEYLEN_192: nk = 4'd6;
            default:    nk = 4'd8;
        endcase
        nk_m1 = 3'(nk - 4'd1);
        nr    = nk + 4'd6;
    end

    // input conditioning for a new request
    always_comb begin
        count_eff = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        blk = {i_block_high, i_block_low};
        for (int n = 0; n < 16; n++) mask[127-8*n -: 8] = {8{5'(n) < count_eff}};
        padded    = blk & mask;
        mode_eff  = (i_cipher_mode > MODE_OFB_DEC) ? MODE_ECB_ENC : i_cipher_mode;
        chain_eff = i_first_block ? i_iv : r_chain;
        err_now   = (mode_eff == MODE_ECB_DEC || mode_eff == MODE_CBC_DEC ||
                     mode_eff == MODE_PCBC_DEC) && (count_eff != 5'd16);
        case (mode_eff)
            MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_DEC, MODE_PCBC_DEC: cipher_in = padded;
            MODE_CBC_ENC, MODE_PCBC_ENC: cipher_in = padded ^ chain_eff;
            default: cipher_in = chain_eff;
        endcase
    end

    assign decrypt = (r_mode == MODE_ECB_DEC || r_mode == MODE_CBC_DEC ||
                      r_mode == MODE_PCBC_DEC);
    assign o_status = '{nr: nr, decrypt: decrypt, err: r_err};

    // key expansion word
    logic [31:0] key_w [8];
    logic [31:0] exp_t;
    logic [31:0] exp_word;
    logic        exp_from_key;
    always_comb begin
        for (int j = 0; j < 8; j++) key_w[j] = i_key[255-32*j -: 32];
        exp_from_key = i_cmd.word_idx < {2'b00, nk};
        exp_t = r_win[0];
        if (r_kmod == 3'd0) begin
            exp_t = f_sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_kmod == 3'd4) begin
            exp_t = f_sub_word(r_win[0]);
        end
        exp_word = exp_from_key ? key_w[i_cmd.word_idx[2:0]] : (r_win[nk_m1] ^ exp_t);
    end

    // round key store, one bank per column
    logic rk_we;
    assign rk_we = i_cmd.exp_step && ({1'b0, i_cmd.word_idx} < MAX_WORDS);

    for (genvar c = 0; c < 4; c++) begin : g_bank
        logic [31:0] r_bank [ROWS];
        always_ff @(posedge i_clk) begin
            if (rk_we && i_cmd.word_idx[1:0] == 2'(c)) begin
                r_bank[i_cmd.word_idx[ROW_W+1:2]] <= exp_word;
            end
            if (i_cmd.rd_en) begin
                r_rk_rd[c] <= r_bank[i_cmd.rd_row[ROW_W-1:0]];
            end
        end
    end

    // words beyond the store read as zero
    logic [127:0] rk;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rk[127-32*c -: 32] = ({1'b0, r_rd_row, 2'(c)} < MAX_WORDS) ? r_rk_rd[c] : '0;
        end
    end

    // shared round unit
    logic [127:0] enc_sh;
    logic [127:0] enc_mx;
    logic [127:0] dec_ak;
    logic [127:0] round_out;
    always_comb begin
        enc_sh = f_shift_rows(f_sub_bytes(r_state, 1'b0), 1'b0);
        enc_mx = i_cmd.round_last ? enc_sh : f_mix_columns(enc_sh, 1'b0);
        dec_ak = f_sub_bytes(f_shift_rows(r_state, 1'b1), 1'b1) ^ rk;
        if (i_cmd.round_first) round_out = r_state ^ rk;
        else if (decrypt) round_out = i_cmd.round_last ? dec_ak : f_mix_columns(dec_ak, 1'b1);
        else round_out = enc_mx ^ rk;
    end

    // mode post-processing
    logic [127:0] n_res;
    logic [127:0] n_chain;
    always_comb begin
        n_res   = r_state;
        n_chain = r_chain;
        case (r_mode)
            MODE_CBC_ENC:  n_chain = r_state;
            MODE_PCBC_ENC: n_chain = r_state ^ r_data;
            MODE_CBC_DEC: begin
                n_res   = r_state ^ r_chain;
                n_chain = r_data;
            end
            MODE_PCBC_DEC: begin
                n_res   = r_state ^ r_chain;
                n_chain = r_data ^ n_res;
            end
            MODE_CFB_ENC: begin
                n_res   = r_state ^ r_data;
                n_chain = n_res;
            end
            MODE_CFB_DEC: begin
                n_res   = r_state ^ r_data;
                n_chain = r_data;
            end
            MODE_OFB_ENC, MODE_OFB_DEC: begin
                n_res   = r_state ^ r_data;
                n_chain = r_state;
            end
            default: ;
        endcase
        if (r_mode >= MODE_CFB_ENC) n_res = n_res & r_mask;
        if (r_err) begin
            n_res   = '0;
            n_chain = r_chain;
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.capture) begin
            r_chain <= chain_eff;
        end else if (i_cmd.finish) begin
            r_chain <= n_chain;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_state <= cipher_in;
            r_data  <= padded;
            r_mask  <= mask;
            r_mode  <= mode_eff;
            r_err   <= err_now;
            r_kmod  <= '0;
            r_rcon  <= 8'h01;
        end
        if (i_cmd.exp_step) begin
            r_win[0] <= exp_word;
            for (int k = 1; k < 8; k++) r_win[k] <= r_win[k-1];
            r_kmod <= (r_kmod == nk_m1) ? 3'd0 : r_kmod + 3'd1;
            if (!exp_from_key && r_kmod == 3'd0) r_rcon <= f_xtime(r_rcon);
        end
        if (i_cmd.rd_en) r_rd_row <= i_cmd.rd_row;
        if (i_cmd.round) r_state <= round_out;
        if (i_cmd.finish) begin
            r_res_high <= n_res[127:64];
            r_res_low  <= n_res[63:0];
            r_len_err  <= r_err;
        end
    end

    assign o_result_high  = r_res_high;
    assign o_result_low   = r_res_low;
    assign o_length_error = r_len_err;

endmodule

### src/aesm_ctrl.sv
module aesm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_first_block,
    input  logic              i_key_write,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output aesm_pkg::t_cmd    o_cmd,
    input  aesm_pkg::t_status i_status
);
    import aesm_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_word;
    logic [3:0] r_step;
    logic       r_keys_ready;
    logic       r_out_valid;

    logic       accept;
    logic       out_free;
    logic       last_word;
    logic       last_step;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_word = r_word == {i_status.nr, 2'b11};
    assign last_step = r_step == i_status.nr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = (i_first_block || !r_keys_ready) ? ST_EXPAND : ST_FETCH;
            end
            ST_EXPAND: if (last_word) n_state = ST_FETCH;
            ST_FETCH:  n_state = i_status.err ? ST_FINISH : ST_ROUND;
            ST_ROUND:  if (last_step) n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.word_idx = r_word;
        case (r_state)
            ST_IDLE:   o_cmd.capture = accept;
            ST_EXPAND: o_cmd.exp_step = 1'b1;
            ST_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = i_status.decrypt ? i_status.nr : 4'd0;
            end
            ST_ROUND: begin
                o_cmd.round       = 1'b1;
                o_cmd.round_first = r_step == 4'd0;
                o_cmd.round_last  = last_step;
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_row      = i_status.decrypt ? (i_status.nr - r_step - 4'd1)
                                                     : (r_step + 4'd1);
            end
            ST_FINISH: o_cmd.finish = out_free;
            default: ;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_word       <= '0;
            r_step       <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.capture) r_word <= '0;
            else if (o_cmd.exp_step) r_word <= r_word + 6'd1;
            if (r_state == ST_FETCH) r_step <= '0;
            else if (o_cmd.round) r_step <= r_step + 4'd1;
            if (i_key_write) r_keys_ready <= 1'b0;
            else if (o_cmd.exp_step && last_word) r_keys_ready <= 1'b1;
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;

    // checks
    a_round_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && last_step) |=> r_state == ST_FINISH)
        else $error("round sequence did not end after the last round");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished request not presented");

    a_keys_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND && last_word && !i_key_write) |=> r_keys_ready)
        else $error("keys not marked ready after expansion");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND |-> r_step <= i_status.nr)
        else $error("round counter past round count");

endmodule

### src/aes_block_cipher_modes.sv
// AES-128/192/256 engine with ECB, CBC, PCBC, CFB-128 and OFB chaining, one
// 128-bit block per request. One shared round unit does one round per cycle:
// a request with keys already expanded goes through capture, key row fetch,
// Nr + 1 rounds and output, and the next request is taken once the engine
// is back in idle. A first block, or the first block after a key or key
// length write, first runs the key schedule at one word per cycle into the
// round key store. Blocks are processed one at a time since the chaining
// value of one block feeds the next. The result register frees the input
// side while a result waits to be taken. Configuration must be written
// only while the engine is idle; the block itself does not enforce this.
module aes_block_cipher_modes #(
    parameter int unsigned MAX_ROUND_KEY_WORDS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_first_block,
    input  logic [4:0]  i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    output logic        o_length_error
);
    import aesm_pkg::*;

    logic [63:0] r_key_word [4];
    logic [1:0]  r_key_length;
    logic [3:0]  r_cipher_mode;
    logic [63:0] r_iv_high;
    logic [63:0] r_iv_low;
    logic        key_write;
    t_cmd        cmd;
    t_status     status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key_word[k] <= '0;
            r_key_length  <= '0;
            r_cipher_mode <= '0;
            r_iv_high     <= '0;
            r_iv_low      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_WORD_0:  r_key_word[0] <= i_cfg_data;
                CFG_KEY_WORD_1:  r_key_word[1] <= i_cfg_data;
                CFG_KEY_WORD_2:  r_key_word[2] <= i_cfg_data;
                CFG_KEY_WORD_3:  r_key_word[3] <= i_cfg_data;
                CFG_KEY_LENGTH:  r_key_length  <= i_cfg_data[1:0];
                CFG_CIPHER_MODE: r_cipher_mode <= i_cfg_data[3:0];
                CFG_IV_HIGH:     r_iv_high     <= i_cfg_data;
                CFG_IV_LOW:      r_iv_low      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // any key material change forces a new key schedule
    assign key_write = i_cfg_we && (i_cfg_idx <= CFG_KEY_LENGTH);

    aesm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_block (i_first_block),
        .i_key_write   (key_write),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    aesm_dp #(
        .MAX_ROUND_KEY_WORDS (MAX_ROUND_KEY_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          ({r_key_word[0], r_key_word[1], r_key_word[2], r_key_word[3]}),
        .i_key_length   (r_key_length),
        .i_cipher_mode  (r_cipher_mode),
        .i_iv           ({r_iv_high, r_iv_low}),
        .i_block_high   (i_block_high),
        .i_block_low    (i_block_low),
        .i_first_block  (i_first_block),
        .i_byte_count   (i_byte_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_high  (o_result_high),
        .o_result_low   (o_result_low),
        .o_length_error (o_length_error)
    );

endmodule

### tb/tb_aes_block_cipher_modes.sv
module tb_aes_block_cipher_modes;
    import aesm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        first;
        logic [4:0]  cnt;
    } t_req;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        err;
    } t_blk_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        i_first_block;
    logic [4:0]  i_byte_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;
    logic        o_length_error;

    aes_block_cipher_modes dut (.*);

    // predictor state and configuration copy
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [31:0]  sched [60];
    int           num_rounds;
    logic [63:0]  key_reg [4];
    logic [1:0]   key_len_reg;
    logic [3:0]   mode_reg;
    logic [63:0]  iv_hi_reg;
    logic [63:0]  iv_lo_reg;
    logic [127:0] chain;
    logic         sched_valid;

    t_req     req_q [$];
    t_blk_res cipher_q [$];
    int       errors;
    int       cycles;
    bit       allow_idle;
    bit       in_acc;
    int       gap_left;
    int       stall_left;

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] ginv(logic [7:0] a);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, a);
            a = gmul(a, a);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [31:0] sub32(logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    // key schedule into the round key words
    function automatic void expand_sched();
        int nk;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (key_len_reg == KEYLEN_128) ? 4 : (key_len_reg == KEYLEN_192) ? 6 : 8;
        num_rounds = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < 4 * (num_rounds + 1); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1B : 8'h00);
            end else if (nk > 6 && i % nk == 4) begin
                t = sub32(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        sched_valid = 1;
    endfunction

    function automatic logic [127:0] add_rk(logic [127:0] s, int r);
        for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= sched[4*r+c];
        return s;
    endfunction

    function automatic logic [127:0] subst(logic [127:0] s, bit inv);
        for (int n = 0; n < 16; n++)
            s[127-8*n -: 8] = inv ? inv_sub[s[127-8*n -: 8]] : fwd_sub[s[127-8*n -: 8]];
        return s;
    endfunction

    function automatic logic [127:0] rows(logic [127:0] s, bit inv);
        logic [127:0] t;
        int o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                o = r + 4 * ((c + r) & 3);
                if (inv) t[127-8*o -: 8] = s[127-8*(r+4*c) -: 8];
                else t[127-8*(r+4*c) -: 8] = s[127-8*o -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mixcol(logic [127:0] s, bit inv);
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] v;
        logic [127:0] o;
        if (inv) begin
            m[0] = 8'h0E; m[1] = 8'h0B; m[2] = 8'h0D; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
            for (int r = 0; r < 4; r++) begin
                v = 0;
                for (int k = 0; k < 4; k++) v ^= gmul(m[(k - r) & 3], a[k]);
                o[127-8*(4*c+r) -: 8] = v;
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] encipher(logic [127:0] s);
        s = add_rk(s, 0);
        for (int r = 1; r <= num_rounds; r++) begin
            s = rows(subst(s, 0), 0);
            if (r != num_rounds) s = mixcol(s, 0);
            s = add_rk(s, r);
        end
        return s;
    endfunction

    function automatic logic [127:0] decipher(logic [127:0] s);
        s = add_rk(s, num_rounds);
        for (int r = num_rounds - 1; r >= 0; r--) begin
            s = add_rk(subst(rows(s, 1), 1), r);
            if (r != 0) s = mixcol(s, 1);
        end
        return s;
    endfunction

    // expected result of one block, chaining value updated
    function automatic t_blk_res cipher_block(t_req q);
        int cnt;
        logic [3:0] mode;
        logic [127:0] data, res, ks, keep;
        t_blk_res e;
        cnt = (q.cnt > 16) ? 16 : q.cnt;
        mode = (mode_reg > MODE_OFB_DEC) ? MODE_ECB_ENC : mode_reg;
        data = {q.hi, q.lo};
        keep = '0;
        for (int n = 0; n < cnt; n++) keep[127-8*n -: 8] = 8'hFF;
        data &= keep;
        if (q.first) chain = {iv_hi_reg, iv_lo_reg};
        if (q.first || !sched_valid) expand_sched();
        res = '0;
        e.err = 0;
        if ((mode == MODE_ECB_DEC || mode == MODE_CBC_DEC || mode == MODE_PCBC_DEC)
                && cnt < 16) begin
            e.err = 1;
        end else begin
            case (mode)
                MODE_ECB_ENC: res = encipher(data);
                MODE_ECB_DEC: res = decipher(data);
                MODE_CBC_ENC, MODE_PCBC_ENC: begin
                    res = encipher(data ^ chain);
                    chain = (mode == MODE_PCBC_ENC) ? (res ^ data) : res;
                end
                MODE_CBC_DEC, MODE_PCBC_DEC: begin
                    res = decipher(data) ^ chain;
                    chain = (mode == MODE_PCBC_DEC) ? (data ^ res) : data;
                end
                default: begin
                    ks = encipher(chain);
                    res = ks ^ data;
                    if (mode == MODE_CFB_ENC) chain = res;
                    else if (mode == MODE_CFB_DEC) chain = data;
                    else chain = ks;
                    res &= keep;
                end
            endcase
        end
        e.hi = res[127:64];
        e.lo = res[63:0];
        return e;
    endfunction

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        t_req q;
        logic nv;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            nv = i_in_valid;
            if (!i_in_valid || in_acc) begin
                nv = 0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (allow_idle && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 10);
                end else if (req_q.size() > 0) begin
                    q = req_q[0];
                    req_q.delete(0);
                    i_block_high <= q.hi;
                    i_block_low <= q.lo;
                    i_first_block <= q.first;
                    i_byte_count <= q.cnt;
                    nv = 1;
                end
            end
            i_in_valid <= nv;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 0;
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // monitor: predict on accepted requests, check results
    always @(posedge i_clk) begin
        t_req q;
        t_blk_res e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            in_acc <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                q.hi = i_block_high;
                q.lo = i_block_low;
                q.first = i_first_block;
                q.cnt = i_byte_count;
                cipher_q.insert(cipher_q.size(), cipher_block(q));
            end
            if (o_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    e = cipher_q[0];
                    cipher_q.delete(0);
                    check_field("result_high", e.hi, o_result_high);
                    check_field("result_low", e.lo, o_result_low);
                    check_field("length_error", e.err, o_length_error);
                end
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx <= CFG_KEY_WORD_3) begin
            key_reg[idx] = val;
            sched_valid = 0;
        end else if (idx == CFG_KEY_LENGTH) begin
            key_len_reg = val[1:0];
            sched_valid = 0;
        end else if (idx == CFG_CIPHER_MODE) begin
            mode_reg = val[3:0];
        end else if (idx == CFG_IV_HIGH) begin
            iv_hi_reg = val;
        end else begin
            iv_lo_reg = val;
        end
    endtask

    task automatic add_req(logic [63:0] hi, logic [63:0] lo, logic first, logic [4:0] cnt);
        t_req q;
        q.hi = hi;
        q.lo = lo;
        q.first = first;
        q.cnt = cnt;
        req_q.insert(req_q.size(), q);
    endtask

    task automatic drain();
        while (req_q.size() > 0 || i_in_valid || cipher_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] x;
        logic [63:0] kv;
        int n_req;
        for (int i = 0; i < 256; i++) begin
            x = ginv(i[7:0]);
            fwd_sub[i] = x ^ rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 3) ^ rol8(x, 4) ^ 8'h63;
            x = rol8(i[7:0], 1) ^ rol8(i[7:0], 3) ^ rol8(i[7:0], 6) ^ 8'h05;
            inv_sub[i] = ginv(x);
        end
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        key_len_reg = KEYLEN_128;
        mode_reg = MODE_ECB_ENC;
        iv_hi_reg = '0;
        iv_lo_reg = '0;
        chain = '0;
        sched_valid = 0;
        errors = 0;
        cycles = 0;
        allow_idle = 1;
        in_acc = 0;
        gap_left = 0;
        stall_left = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_KEY_WORD_0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_block_high = '0;
        i_block_low = '0;
        i_first_block = 0;
        i_byte_count = '0;
        i_out_ready = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        for (int ph = 0; ph < 34; ph++) begin
            if (ph >= 30) allow_idle = 0;
            // settings: all-zero and all-one extremes first, then a sweep
            for (int k = 0; k < 4; k++) begin
                kv = (ph == 0) ? '0 : (ph == 1) ? '1 : rnd64();
                cfg_write(CFG_KEY_WORD_0 + k[2:0], kv);
            end
            cfg_write(CFG_KEY_LENGTH, (ph < 16) ? ph % 4 : $urandom_range(0, 3));
            cfg_write(CFG_CIPHER_MODE, (ph < 16) ? ph : $urandom_range(0, 9));
            cfg_write(CFG_IV_HIGH, (ph == 0) ? '0 : (ph == 1) ? '1 : rnd64());
            cfg_write(CFG_IV_LOW, (ph == 0) ? '0 : (ph == 1) ? '1 : rnd64());
            @(negedge i_clk);
            i_cfg_we <= 0;

            if (ph < 2) begin
                // extremes of data and byte count, ECB in both directions
                add_req('0, '0, 1, 16);
                add_req('1, '1, 0, 16);
                add_req('1, '1, 0, 0);
                add_req(rnd64(), rnd64(), 0, 1);
                add_req(rnd64(), rnd64(), 0, 15);
                add_req(rnd64(), rnd64(), 0, 17);
                add_req('1, '1, 1, 31);
                add_req(rnd64(), rnd64(), 0, 8);
                add_req(rnd64(), rnd64(), 1, 16);
                add_req(rnd64(), rnd64(), 0, 16);
                add_req(rnd64(), rnd64(), 0, 16);
                add_req(rnd64(), rnd64(), 0, 16);
            end else begin
                // messages: a first block followed by continuation blocks
                n_req = (ph < 16) ? 25 : 30;
                for (int k = 0; k < n_req; k++)
                    add_req(rnd64(), rnd64(), (k == 0) || ($urandom_range(0, 7) == 0),
                            ($urandom_range(0, 9) < 7) ? 5'd16 : 5'($urandom_range(0, 31)));
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
